>>> sv/tie_pkg.sv
`default_nettype none

package tie_pkg;

   localparam int WORD_W    = 32;
   localparam int REG_IDX_W = 5;
   localparam int PC_W      = 9;

   localparam logic [7:0] OP_PRINT = 8'd0;
   localparam logic [7:0] OP_IMM   = 8'd1;
   localparam logic [7:0] OP_ADD   = 8'd2;
   localparam logic [7:0] OP_STORE = 8'd3;
   localparam logic [7:0] OP_LOAD  = 8'd4;
   localparam logic [7:0] OP_MUL   = 8'd5;
   localparam logic [7:0] OP_JMP   = 8'd6;
   localparam logic [7:0] OP_BEQ   = 8'd7;
   localparam logic [7:0] OP_BNE   = 8'd8;
   localparam logic [7:0] OP_HALT  = 8'd9;
   localparam logic [7:0] OP_MARK  = 8'd10;

   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] addr;
      logic [WORD_W-1:0]    data;
   } rf_wr_type;

   // port x always reads r[b]
   function automatic logic uses_x(input logic [7:0] op);
      return op == OP_ADD || op == OP_STORE || op == OP_LOAD || op == OP_MUL ||
             op == OP_BEQ || op == OP_BNE;
   endfunction

   function automatic logic uses_y(input logic [7:0] op);
      return op == OP_PRINT || op == OP_ADD || op == OP_STORE || op == OP_MUL ||
             op == OP_BEQ || op == OP_BNE;
   endfunction

   function automatic logic writes_reg(input logic [7:0] op);
      return op == OP_IMM || op == OP_ADD || op == OP_LOAD || op == OP_MUL;
   endfunction

   // port y reads r[c] for add/mul, r0 for print, r[a] otherwise
   function automatic logic [REG_IDX_W-1:0] y_index(input logic [7:0] op,
                                                    input logic [7:0] fa,
                                                    input logic [7:0] fc);
      logic [REG_IDX_W-1:0] idx;
      if (op == OP_ADD || op == OP_MUL) begin
         idx = fc[REG_IDX_W-1:0];
      end else if (op == OP_PRINT) begin
         idx = '0;
      end else begin
         idx = fa[REG_IDX_W-1:0];
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

>>> sv/tie_ifs.sv
`default_nettype none

interface tie_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] opcode;
   logic [7:0] field_a;
   logic [7:0] field_b;
   logic [7:0] field_c;

   modport source (output valid, output opcode, output field_a, output field_b,
                   output field_c, input ready);
   modport sink (input valid, input opcode, input field_a, input field_b,
                 input field_c, output ready);
endinterface

interface tie_rsp_if;
   logic               valid;
   logic               ready;
   logic               print_valid;
   logic signed [31:0] print_value;
   logic               marker_seen;
   logic [8:0]         next_pc;
   logic               halted;

   modport source (output valid, output print_valid, output print_value,
                   output marker_seen, output next_pc, output halted, input ready);
   modport sink (input valid, input print_valid, input print_value,
                 input marker_seen, input next_pc, input halted, output ready);
endinterface

`default_nettype wire

>>> sv/toy_isa_instruction_execute.sv
`default_nettype none

// Executes instructions of a 32 x 32-bit register machine with a data RAM of
// RAM_WORDS words. The register file is read when an instruction is accepted;
// operands are resolved and results and the next PC formed in the execute stage
// (the response is registered there), the RAM address is reduced and the RAM
// accessed in the memory stage, and register write-back follows from the
// write-back stage. Results are forwarded to waiting instructions, so the
// sustained rate is one instruction per cycle while responses are taken; an
// instruction that reads the destination of the load just ahead of it waits
// for the RAM's registered read data. After reset the data RAM is zeroed one
// word a cycle, and no instruction is accepted until the sweep is done.
module toy_isa_instruction_execute #(
   parameter int RAM_WORDS      = 1024,
   parameter int PROGRAM_LENGTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tie_req_if.sink    req_port,
   tie_rsp_if.source  rsp_port
);

   localparam int W   = tie_pkg::WORD_W;
   localparam int RW  = tie_pkg::REG_IDX_W;
   localparam int PW  = tie_pkg::PC_W;
   localparam int AW  = $clog2(RAM_WORDS);

   localparam logic [63:0]   RECIP_FULL = 64'h1_0000_0000 / 64'(RAM_WORDS);
   localparam logic [W-1:0]  RECIP      = RECIP_FULL[W-1:0];
   localparam logic [W:0]    NWORDS     = (W + 1)'(RAM_WORDS);
   localparam logic [PW-1:0] PROG_LEN   = PW'(PROGRAM_LENGTH);
   localparam logic [PW-1:0] HALT_PC    = PW'(PROGRAM_LENGTH + 1);

   // execute stage
   logic          b_valid_ff, b_fresh_ff;
   logic [7:0]    b_op_ff, b_a_ff, b_b_ff, b_c_ff;
   logic [RW-1:0] b_xi_ff, b_yi_ff;
   logic [W-1:0]  b_x_ff, b_y_ff;
   logic [PW-1:0] pc_ff;

   // memory stage
   logic          c_valid_ff, c_wr_ff, c_load_ff, c_store_ff;
   logic [RW-1:0] c_dest_ff;
   logic [W-1:0]  c_res_ff, c_v_ff, c_q_ff, c_sdata_ff;

   // write-back stage
   logic          d_valid_ff, d_load_ff;
   logic [RW-1:0] d_dest_ff;
   logic [W-1:0]  d_res_ff;

   // response register
   logic          rsp_valid_ff, rsp_pvalid_ff, rsp_mark_ff, rsp_halted_ff;
   logic [W-1:0]  rsp_pvalue_ff;
   logic [PW-1:0] rsp_pc_ff;

   logic                 ram_busy;
   logic [W-1:0]         ram_rdata;
   logic [W-1:0]         rf_x, rf_y;
   tie_pkg::rf_wr_type   rf_wr;

   logic          req_accept, b_advance, hazard;
   logic [W-1:0]  x_src, y_src, x_fwd, y_fwd;
   logic          x_wait, y_wait;
   logic [W-1:0]  sum, prod, res_in;
   logic [2*W-1:0] recip_full;
   logic [PW-1:0] pc_plus, next_pc_in;
   logic [2*W:0]  red_full;
   logic [W:0]    rem_raw, rem_fix;
   logic [AW-1:0] ram_addr;

   assign rf_wr.en   = d_valid_ff;
   assign rf_wr.addr = d_dest_ff;
   assign rf_wr.data = d_load_ff ? ram_rdata : d_res_ff;

   tie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_addr_x (req_port.field_b[RW-1:0]),
      .rd_addr_y (tie_pkg::y_index(req_port.opcode, req_port.field_a, req_port.field_c)),
      .wr        (rf_wr),
      .rd_data_x (rf_x),
      .rd_data_y (rf_y)
   );

   tie_dram #(.WORDS(RAM_WORDS), .AW(AW)) u_dram (
      .clock   (clock),
      .reset   (reset),
      .busy    (ram_busy),
      .wr_en   (c_valid_ff && c_store_ff),
      .addr    (ram_addr),
      .wr_data (c_sdata_ff),
      .rd_data (ram_rdata)
   );

   // operand resolution: memory stage first, then write-back
   assign x_src = b_fresh_ff ? rf_x : b_x_ff;
   assign y_src = b_fresh_ff ? rf_y : b_y_ff;

   always_comb begin
      x_fwd  = x_src;
      x_wait = 1'b0;
      if (c_valid_ff && c_wr_ff && c_dest_ff == b_xi_ff) begin
         x_fwd  = c_res_ff;
         x_wait = c_load_ff;
      end else if (rf_wr.en && rf_wr.addr == b_xi_ff) begin
         x_fwd = rf_wr.data;
      end
      y_fwd  = y_src;
      y_wait = 1'b0;
      if (c_valid_ff && c_wr_ff && c_dest_ff == b_yi_ff) begin
         y_fwd  = c_res_ff;
         y_wait = c_load_ff;
      end else if (rf_wr.en && rf_wr.addr == b_yi_ff) begin
         y_fwd = rf_wr.data;
      end
   end

   assign hazard = (x_wait && tie_pkg::uses_x(b_op_ff)) ||
                   (y_wait && tie_pkg::uses_y(b_op_ff));
   assign b_advance = b_valid_ff && !hazard && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = !ram_busy && (!b_valid_ff || b_advance);
   assign req_accept = req_port.valid && req_port.ready;

   assign sum        = x_fwd + y_fwd;
   assign prod       = x_fwd * y_fwd;
   assign recip_full = (2 * W)'(x_fwd) * (2 * W)'(RECIP);
   assign pc_plus    = pc_ff + PW'(1);

   always_comb begin
      res_in     = '0;
      next_pc_in = pc_plus;
      unique case (b_op_ff)
         tie_pkg::OP_IMM:  res_in = {16'b0, b_b_ff, b_c_ff};
         tie_pkg::OP_ADD:  res_in = sum;
         tie_pkg::OP_MUL:  res_in = prod;
         tie_pkg::OP_JMP:  next_pc_in = {1'b0, b_c_ff};
         tie_pkg::OP_BEQ:  if (y_fwd == x_fwd) next_pc_in = {1'b0, b_c_ff};
         tie_pkg::OP_BNE:  if (y_fwd != x_fwd) next_pc_in = {1'b0, b_c_ff};
         tie_pkg::OP_HALT: next_pc_in = HALT_PC;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_fresh_ff <= 1'b0;
      end else if (req_accept) begin
         b_valid_ff <= 1'b1;
         b_fresh_ff <= 1'b1;
      end else begin
         b_fresh_ff <= 1'b0;
         if (b_advance) begin
            b_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         b_op_ff <= req_port.opcode;
         b_a_ff  <= req_port.field_a;
         b_b_ff  <= req_port.field_b;
         b_c_ff  <= req_port.field_c;
         b_xi_ff <= req_port.field_b[RW-1:0];
         b_yi_ff <= tie_pkg::y_index(req_port.opcode, req_port.field_a, req_port.field_c);
      end
      // a waiting instruction keeps its resolved operands
      if (!req_accept && b_valid_ff) begin
         b_x_ff <= x_fwd;
         b_y_ff <= y_fwd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
      end else begin
         c_valid_ff <= b_advance;
         d_valid_ff <= c_valid_ff && c_wr_ff;
         if (b_advance) begin
            pc_ff        <= next_pc_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_advance) begin
         rsp_pvalid_ff <= b_op_ff == tie_pkg::OP_PRINT;
         rsp_pvalue_ff <= (b_op_ff == tie_pkg::OP_PRINT) ? y_fwd : '0;
         rsp_mark_ff   <= b_op_ff == tie_pkg::OP_MARK;
         rsp_pc_ff     <= next_pc_in;
         rsp_halted_ff <= next_pc_in >= PROG_LEN;
         c_wr_ff       <= tie_pkg::writes_reg(b_op_ff);
         c_load_ff     <= b_op_ff == tie_pkg::OP_LOAD;
         c_store_ff    <= b_op_ff == tie_pkg::OP_STORE;
         c_dest_ff     <= b_a_ff[RW-1:0];
         c_res_ff      <= res_in;
         c_v_ff        <= x_fwd;
         c_q_ff        <= recip_full[2*W-1:W];
         c_sdata_ff    <= y_fwd;
      end
      d_load_ff <= c_load_ff;
      d_dest_ff <= c_dest_ff;
      d_res_ff  <= c_res_ff;
   end

   // address = value mod RAM_WORDS; the quotient estimate is low by at most one
   assign red_full = (2 * W + 1)'(c_q_ff) * (2 * W + 1)'(NWORDS);
   assign rem_raw  = {1'b0, c_v_ff} - red_full[W:0];
   assign rem_fix  = (rem_raw >= NWORDS) ? rem_raw - NWORDS : rem_raw;
   assign ram_addr = rem_fix[AW-1:0];

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.print_valid = rsp_pvalid_ff;
   assign rsp_port.print_value = $signed(rsp_pvalue_ff);
   assign rsp_port.marker_seen = rsp_mark_ff;
   assign rsp_port.next_pc     = rsp_pc_ff;
   assign rsp_port.halted      = rsp_halted_ff;

endmodule

`default_nettype wire

>>> sv/tie_regfile.sv
`default_nettype none

module tie_regfile (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [tie_pkg::REG_IDX_W-1:0]      rd_addr_x,
   input  wire logic [tie_pkg::REG_IDX_W-1:0]      rd_addr_y,
   input  wire tie_pkg::rf_wr_type                 wr,
   output logic      [tie_pkg::WORD_W-1:0]         rd_data_x,
   output logic      [tie_pkg::WORD_W-1:0]         rd_data_y
);

   localparam int DEPTH = 2 ** tie_pkg::REG_IDX_W;

   logic [tie_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]           valid_ff;
   logic [tie_pkg::WORD_W-1:0] rd_x_ff;
   logic [tie_pkg::WORD_W-1:0] rd_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // write-first: a write at the read edge is passed straight through
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (wr.en && wr.addr == rd_addr_x) begin
         rd_x_ff <= wr.data;
      end else if (valid_ff[rd_addr_x]) begin
         rd_x_ff <= mem_ff[rd_addr_x];
      end else begin
         rd_x_ff <= '0;
      end
      if (wr.en && wr.addr == rd_addr_y) begin
         rd_y_ff <= wr.data;
      end else if (valid_ff[rd_addr_y]) begin
         rd_y_ff <= mem_ff[rd_addr_y];
      end else begin
         rd_y_ff <= '0;
      end
   end

   assign rd_data_x = rd_x_ff;
   assign rd_data_y = rd_y_ff;

endmodule

`default_nettype wire

>>> sv/tie_dram.sv
`default_nettype none

module tie_dram #(
   parameter int WORDS = 1024,
   parameter int AW    = 10
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   output logic                            busy,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              addr,
   input  wire logic [tie_pkg::WORD_W-1:0] wr_data,
   output logic      [tie_pkg::WORD_W-1:0] rd_data
);

   localparam logic [AW-1:0] LAST = AW'(WORDS - 1);

   logic [tie_pkg::WORD_W-1:0] mem_ff [WORDS];
   logic [tie_pkg::WORD_W-1:0] rd_ff;
   logic                       clr_active_ff;
   logic [AW-1:0]              clr_addr_ff;

   // zeroing sweep after reset, one word a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem_ff[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end

   assign busy    = clr_active_ff;
   assign rd_data = rd_ff;

endmodule

`default_nettype wire
